### src/baq_pkg.sv
// Shared widths, note tables and classification functions for the note quantizer.
package baq_pkg;

	localparam int SAMPLE_W    = 10;
	localparam int NOTE_W      = 4;
	localparam int DUTY_W      = 13;
	localparam int NUM_NOTES   = 12;
	localparam int QUEUE_DEPTH = 4;
	localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

	localparam logic [NOTE_W-1:0] NOTE_NONE = NOTE_W'(0);

	// Bin k matches when BIN_LO[k] < avg < BIN_HI[k]; lowest k wins.
	localparam logic [SAMPLE_W-1:0] BIN_HI [0:NUM_NOTES] = '{
		10'd0, 10'd932, 10'd850, 10'd749, 10'd653, 10'd554, 10'd470,
		10'd400, 10'd339, 10'd286, 10'd250, 10'd204, 10'd176
	};
	localparam logic [SAMPLE_W-1:0] BIN_LO [0:NUM_NOTES] = '{
		10'd0, 10'd849, 10'd748, 10'd562, 10'd553, 10'd469, 10'd399,
		10'd338, 10'd285, 10'd249, 10'd203, 10'd175, 10'd148
	};
	localparam logic [DUTY_W-1:0] DUTY_TABLE [0:NUM_NOTES] = '{
		13'd0, 13'd2000, 13'd2470, 13'd2940, 13'd3420, 13'd3890, 13'd4360,
		13'd4830, 13'd5300, 13'd5780, 13'd6430, 13'd6720, 13'd7190
	};

	typedef struct packed {
		logic full;
		logic empty;
	} q_stat_t;

	function automatic logic [NOTE_W-1:0] classify(input logic [SAMPLE_W-1:0] avg);
		logic [NOTE_W-1:0] note;
		note = NOTE_NONE;
		// scan from the top so the lowest matching bin is left standing
		for (int k = NUM_NOTES; k >= 1; k--) begin
			if ((avg < BIN_HI[k]) && (avg > BIN_LO[k]))
				note = NOTE_W'(k);
		end
		return note;
	endfunction

	function automatic logic [DUTY_W-1:0] duty_of(input logic [NOTE_W-1:0] note);
		logic [DUTY_W-1:0] duty;
		duty = '0;
		if (note <= NOTE_W'(NUM_NOTES))
			duty = DUTY_TABLE[note];
		return duty;
	endfunction

endpackage

### src/baq_front.sv
// Front end: accumulates samples and pushes each completed block sum into the queue.
module baq_front #(
	parameter int BLOCK_LEN = 20,
	parameter int SUM_W     = 15
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         in_valid,
	output logic                         in_ready,
	input  logic [baq_pkg::SAMPLE_W-1:0] in_sample,
	input  baq_pkg::q_stat_t             q_stat,
	output logic                         push,
	output logic [SUM_W-1:0]             push_sum
);

	localparam int CNT_W = (BLOCK_LEN > 1) ? $clog2(BLOCK_LEN) : 1;
	localparam logic [CNT_W-1:0] LAST = CNT_W'(BLOCK_LEN - 1);

	logic [CNT_W-1:0] count_q;
	logic [SUM_W-1:0] sum_q;
	logic [SUM_W-1:0] sum_next;
	logic             accept;
	logic             closing;

	assign in_ready = !q_stat.full;
	assign accept   = in_valid && in_ready;
	assign sum_next = sum_q + SUM_W'(in_sample);
	assign closing  = (count_q >= LAST);
	assign push     = accept && closing;
	assign push_sum = sum_next;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			sum_q   <= '0;
		end else if (accept) begin
			if (closing) begin
				count_q <= '0;
				sum_q   <= '0;
			end else begin
				count_q <= count_q + CNT_W'(1);
				sum_q   <= sum_next;
			end
		end
	end

endmodule

### src/baq_queue.sv
// Short register queue that carries block sums from the front end to the back end.
module baq_queue #(
	parameter int WIDTH = 15
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  logic [WIDTH-1:0] push_data,
	input  logic             pop,
	output logic [WIDTH-1:0] pop_data,
	output baq_pkg::q_stat_t stat
);

	logic [WIDTH-1:0]           slot_q [baq_pkg::QUEUE_DEPTH];
	logic [baq_pkg::QPTR_W-1:0] wr_ptr_q;
	logic [baq_pkg::QPTR_W-1:0] rd_ptr_q;
	logic [baq_pkg::QPTR_W:0]   fill_q;
	logic                       do_push;
	logic                       do_pop;

	assign stat.full  = (fill_q == (baq_pkg::QPTR_W+1)'(baq_pkg::QUEUE_DEPTH));
	assign stat.empty = (fill_q == '0);
	assign do_push    = push && !stat.full;
	assign do_pop     = pop && !stat.empty;
	assign pop_data   = slot_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (do_push)
			slot_q[wr_ptr_q] <= push_data;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			fill_q   <= '0;
		end else begin
			if (do_push)
				wr_ptr_q <= wr_ptr_q + baq_pkg::QPTR_W'(1);
			if (do_pop)
				rd_ptr_q <= rd_ptr_q + baq_pkg::QPTR_W'(1);
			if (do_push && !do_pop)
				fill_q <= fill_q + (baq_pkg::QPTR_W+1)'(1);
			else if (do_pop && !do_push)
				fill_q <= fill_q - (baq_pkg::QPTR_W+1)'(1);
		end
	end

endmodule

### src/baq_back.sv
// Back end: divides each block sum, bins the average and holds the result word.
module baq_back #(
	parameter int BLOCK_LEN = 20,
	parameter int SUM_W     = 15
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  baq_pkg::q_stat_t             q_stat,
	input  logic [SUM_W-1:0]             pop_sum,
	output logic                         pop,
	output logic                         out_valid,
	input  logic                         out_ready,
	output logic [baq_pkg::NOTE_W-1:0]   out_note,
	output logic                         out_changed,
	output logic [baq_pkg::DUTY_W-1:0]   out_duty,
	output logic [baq_pkg::SAMPLE_W-1:0] out_avg
);

	// floor(sum / BLOCK_LEN) == (sum * MULT) >> SHIFT for every sum below 2**SUM_W
	localparam int    LOG_D  = $clog2(BLOCK_LEN);
	localparam int    SHIFT  = SUM_W + LOG_D;
	localparam int    MULT_W = SUM_W + 1;
	localparam int    PROD_W = SUM_W + MULT_W;
	localparam longint MULT_V = ((64'd1 << SHIFT) + BLOCK_LEN - 1) / BLOCK_LEN;
	localparam logic [MULT_W-1:0] MULT = MULT_W'(MULT_V);

	logic                         adv;
	logic                         valid_s1;
	logic [PROD_W-1:0]            prod_s1;
	logic [baq_pkg::SAMPLE_W-1:0] avg;
	logic [baq_pkg::NOTE_W-1:0]   note;
	logic [baq_pkg::NOTE_W-1:0]   prev_note_q;
	logic [baq_pkg::DUTY_W-1:0]   duty_q;
	logic                         out_valid_q;
	logic                         changed_q;
	logic [baq_pkg::SAMPLE_W-1:0] avg_q;

	// advance the whole back end only when the result word is free
	assign adv  = !out_valid_q || out_ready;
	assign pop  = adv && !q_stat.empty;
	assign avg  = prod_s1[SHIFT +: baq_pkg::SAMPLE_W];
	assign note = baq_pkg::classify(avg);

	always_ff @(posedge clk) begin
		if (pop)
			prod_s1 <= PROD_W'(pop_sum) * PROD_W'(MULT);
		if (adv && valid_s1) begin
			avg_q     <= avg;
			changed_q <= (note != prev_note_q);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			out_valid_q <= 1'b0;
			prev_note_q <= baq_pkg::NOTE_NONE;
			duty_q      <= '0;
		end else if (adv) begin
			valid_s1    <= !q_stat.empty;
			out_valid_q <= valid_s1;
			if (valid_s1) begin
				prev_note_q <= note;
				if (note != prev_note_q)
					duty_q <= baq_pkg::duty_of(note);
			end
		end
	end

	assign out_valid   = out_valid_q;
	assign out_note    = prev_note_q;
	assign out_changed = changed_q;
	assign out_duty    = duty_q;
	assign out_avg     = avg_q;

endmodule

### src/block_average_note_quantizer.sv
// Top level of the block-average note quantizer: front end, sum queue and back end.
//
//  port group | direction | tdata fields (low bit up)
//  s_axis     | in        | sample[9:0], zero pad to 16 bits
//  m_axis     | out       | note[3:0], note_changed[4], duty_count[17:5],
//             |           | block_average[27:18], zero pad to 32 bits
//
// One sample is taken every cycle while the sum queue has room.
// The edge that takes the last sample of a block pushes its sum into the queue; when the back
// end advances, the sum is loaded into the product register, then binned into the result word.
// The four-entry sum queue lets the sample side keep running while m_axis stalls, until it fills.
// arst_n clears the sample count, the running sum, the last note and the duty count.
module block_average_note_quantizer #(
	parameter int BLOCK_LEN = 20
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [15:0] s_axis_tdata,   // sample[9:0]
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [31:0] m_axis_tdata    // note, note_changed, duty_count, block_average
);

	localparam int SUM_W = baq_pkg::SAMPLE_W + $clog2(BLOCK_LEN);

	baq_pkg::q_stat_t             q_stat;
	logic                         push;
	logic [SUM_W-1:0]             push_sum;
	logic                         pop;
	logic [SUM_W-1:0]             pop_sum;
	logic [baq_pkg::NOTE_W-1:0]   note;
	logic                         note_changed;
	logic [baq_pkg::DUTY_W-1:0]   duty_count;
	logic [baq_pkg::SAMPLE_W-1:0] block_average;

	baq_front #(
		.BLOCK_LEN(BLOCK_LEN),
		.SUM_W    (SUM_W)
	) u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_axis_tvalid),
		.in_ready (s_axis_tready),
		.in_sample(s_axis_tdata[baq_pkg::SAMPLE_W-1:0]),
		.q_stat   (q_stat),
		.push     (push),
		.push_sum (push_sum)
	);

	baq_queue #(
		.WIDTH(SUM_W)
	) u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.push_data(push_sum),
		.pop      (pop),
		.pop_data (pop_sum),
		.stat     (q_stat)
	);

	baq_back #(
		.BLOCK_LEN(BLOCK_LEN),
		.SUM_W    (SUM_W)
	) u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.q_stat     (q_stat),
		.pop_sum    (pop_sum),
		.pop        (pop),
		.out_valid  (m_axis_tvalid),
		.out_ready  (m_axis_tready),
		.out_note   (note),
		.out_changed(note_changed),
		.out_duty   (duty_count),
		.out_avg    (block_average)
	);

	assign m_axis_tdata = {4'b0000, block_average, duty_count, note_changed, note};

endmodule

### src/baq_checker.sv
// Port-level checker for the note quantizer, bound to the top level.
module baq_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        m_axis_tvalid,
	input logic        m_axis_tready,
	input logic [31:0] m_axis_tdata
);

	logic [3:0]  note;
	logic [12:0] duty;
	logic [9:0]  avg;

	assign note = m_axis_tdata[3:0];
	assign duty = m_axis_tdata[17:5];
	assign avg  = m_axis_tdata[27:18];

	// hold a stalled word
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
		else $error("m_axis word changed while stalled");

	a_reset_quiet: assert property (@(posedge clk)
		!arst_n |-> !m_axis_tvalid)
		else $error("m_axis valid during reset");

	a_note_bin: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> note == baq_pkg::classify(avg))
		else $error("note does not match the bin of the block average");

	a_duty_note: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> duty == baq_pkg::duty_of(note))
		else $error("duty count out of step with the note");

	a_pad_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> m_axis_tdata[31:28] == 4'b0000)
		else $error("m_axis pad bits set");

endmodule

bind block_average_note_quantizer baq_checker u_baq_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.m_axis_tvalid(m_axis_tvalid),
	.m_axis_tready(m_axis_tready),
	.m_axis_tdata (m_axis_tdata)
);
